// ----- hw/rtl/dfa_pkg.sv -----
`timescale 1ns / 1ps

package dfa_pkg;

  // Default sizes of the automaton.
  localparam int unsigned NumStatesDef = 16;
  localparam int unsigned SlotsDef     = 8;

  // Fixed widths of the item fields.
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StateW   = 4;
  localparam int unsigned SlotIdxW = 3;
  localparam int unsigned SymW     = 8;
  localparam int unsigned CntW     = 4;

  // Command codes carried by each input item.
  localparam logic [CmdW-1:0] CMD_SET_ACCEPT = 3'd0;
  localparam logic [CmdW-1:0] CMD_WRITE_SLOT = 3'd1;
  localparam logic [CmdW-1:0] CMD_SET_COUNT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_RESTART    = 3'd3;
  localparam logic [CmdW-1:0] CMD_SYMBOL     = 3'd4;

  // Class codes of a class slot.
  localparam logic [SymW-1:0] CLASS_ANY   = 8'd0;
  localparam logic [SymW-1:0] CLASS_SPACE = 8'd1;
  localparam logic [SymW-1:0] CLASS_DIGIT = 8'd2;

  // Characters used by the classes.
  localparam logic [SymW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [SymW-1:0] CHAR_LF    = 8'h0A;
  localparam logic [SymW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [SymW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SymW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SymW-1:0] CHAR_NINE  = 8'h39;

  // One transition slot as stored in the table memory.
  typedef struct packed {
    logic              kind;
    logic [SymW-1:0]   code;
    logic [StateW-1:0] target;
  } slot_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the item and read the current state's slot row
    logic exec;  // apply the item and load the result register
  } dfa_cmd_t;

endpackage

// ----- hw/rtl/dfa_ctrl.sv -----
`timescale 1ns / 1ps

module dfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output dfa_pkg::dfa_cmd_t ctl_o
);
  import dfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;
  logic        out_free;

  assign in_accept = s_tvalid_i && s_tready_o;
  assign out_free  = !out_valid_q || m_tready_i;

  // Sequencing: take an item, then apply it once the result register is free.
  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  // Only one item is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_tready_o)
    else $error("dfa_ctrl: item accepted while another is in flight");

  // Applying an item always presents a result next cycle.
  a_exec_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.exec |=> m_tvalid_o)
    else $error("dfa_ctrl: applied item did not present a result");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.exec |-> (!m_tvalid_o || m_tready_i))
    else $error("dfa_ctrl: result register overwritten before it was taken");

endmodule

// ----- hw/rtl/dfa_datapath.sv -----
`timescale 1ns / 1ps

module dfa_datapath #(
  parameter int unsigned NUM_STATES      = dfa_pkg::NumStatesDef,
  parameter int unsigned SLOTS_PER_STATE = dfa_pkg::SlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dfa_pkg::dfa_cmd_t             ctl_i,
  input  logic [dfa_pkg::CmdW-1:0]      command_i,
  input  logic [dfa_pkg::StateW-1:0]    state_index_i,
  input  logic [dfa_pkg::SlotIdxW-1:0]  slot_index_i,
  input  logic                          entry_kind_i,
  input  logic [dfa_pkg::SymW-1:0]      symbol_i,
  input  logic [dfa_pkg::StateW-1:0]    target_state_i,
  input  logic                          accept_flag_i,
  input  logic [dfa_pkg::CntW-1:0]      slot_count_i,
  output logic [dfa_pkg::StateW-1:0]    current_index_o,
  output logic                          accepting_o,
  output logic                          matched_o
);
  import dfa_pkg::*;

  localparam int unsigned StIdxW  = $clog2(NUM_STATES);
  localparam int unsigned SlotW   = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
  localparam int unsigned CountW  = $clog2(SLOTS_PER_STATE + 1);

  // Captured item fields.
  logic [CmdW-1:0]     cmd_q;
  logic [StateW-1:0]   st_q;
  logic [SlotIdxW-1:0] slot_q;
  logic                kind_q;
  logic [SymW-1:0]     sym_q;
  logic [StateW-1:0]   trg_q;
  logic                acc_q;
  logic [CntW-1:0]     cnt_q;

  // Automaton state.
  logic [StateW-1:0]   cur_q, cur_d;
  logic                flags_q  [NUM_STATES];
  logic [CountW-1:0]   counts_q [NUM_STATES];

  // Transition table: one row of slots per state.
  slot_entry_t [SLOTS_PER_STATE-1:0] tbl_mem [NUM_STATES];
  slot_entry_t [SLOTS_PER_STATE-1:0] row_q;

  // Result register.
  logic                acc_out_q;
  logic                matched_q;

  logic                st_ok, slot_ok, trg_ok;
  logic [StIdxW-1:0]   st_idx, cur_idx, nxt_idx;
  logic [SlotW-1:0]    slot_idx;
  logic [CountW-1:0]   cnt_sat, cnt_cur;
  logic [SLOTS_PER_STATE-1:0] hit, first_hit;
  logic [StateW-1:0]   pick_trg;
  logic                any_hit;
  logic                acc_d;
  slot_entry_t         new_entry;

  function automatic logic slot_match(slot_entry_t e, logic [SymW-1:0] s);
    logic m;
    m = 1'b0;
    if (!e.kind) begin
      m = (s == e.code);
    end else begin
      unique case (e.code)
        CLASS_ANY:   m = 1'b1;
        CLASS_SPACE: m = (s == CHAR_SPACE) || (s == CHAR_TAB) ||
                         (s == CHAR_LF) || (s == CHAR_CR);
        CLASS_DIGIT: m = (s >= CHAR_ZERO) && (s <= CHAR_NINE);
        default:     m = 1'b0;
      endcase
    end
    return m;
  endfunction

  // Range checks and indexes for the load commands.
  assign st_ok    = 32'(st_q) < NUM_STATES;
  assign slot_ok  = 32'(slot_q) < SLOTS_PER_STATE;
  assign trg_ok   = 32'(trg_q) < NUM_STATES;
  assign st_idx   = StIdxW'(st_q);
  assign slot_idx = SlotW'(slot_q);
  assign cur_idx  = StIdxW'(cur_q);
  assign cnt_sat  = (32'(cnt_q) > SLOTS_PER_STATE) ? CountW'(SLOTS_PER_STATE)
                                                   : CountW'(cnt_q);
  assign new_entry = '{kind: kind_q, code: sym_q, target: trg_q};

  // Capture the item as it is accepted.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      st_q   <= state_index_i;
      slot_q <= slot_index_i;
      kind_q <= entry_kind_i;
      sym_q  <= symbol_i;
      trg_q  <= target_state_i;
      acc_q  <= accept_flag_i;
      cnt_q  <= slot_count_i;
    end
  end

  // Table memory: one slot written, one whole row read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && (cmd_q == CMD_WRITE_SLOT) && st_ok && slot_ok && trg_ok) begin
      tbl_mem[st_idx][slot_idx] <= new_entry;
    end
    if (ctl_i.load) begin
      row_q <= tbl_mem[cur_idx];
    end
  end

  // Compare every valid slot against the symbol, then keep the first hit.
  assign cnt_cur = counts_q[cur_idx];

  always_comb begin
    for (int i = 0; i < SLOTS_PER_STATE; i++) begin
      hit[i] = (i < int'(cnt_cur)) && slot_match(row_q[i], sym_q);
    end
  end

  assign first_hit = hit & (~hit + 1'b1);
  assign any_hit   = |hit;

  always_comb begin
    pick_trg = '0;
    for (int i = 0; i < SLOTS_PER_STATE; i++) begin
      pick_trg = pick_trg | (first_hit[i] ? row_q[i].target : '0);
    end
  end

  // Next state of the automaton.
  always_comb begin
    unique case (cmd_q)
      CMD_RESTART: cur_d = '0;
      CMD_SYMBOL:  cur_d = any_hit ? pick_trg : cur_q;
      default:     cur_d = cur_q;
    endcase
  end

  // Accepting flag of the new state, including a flag written by this item.
  assign nxt_idx = StIdxW'(cur_d);
  assign acc_d   = ((cmd_q == CMD_SET_ACCEPT) && st_ok && (st_q == cur_d)) ? acc_q
                                                                           : flags_q[nxt_idx];

  // State registers, flags and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        flags_q[i]  <= 1'b0;
        counts_q[i] <= '0;
      end
    end else if (ctl_i.exec) begin
      cur_q <= cur_d;
      if ((cmd_q == CMD_SET_ACCEPT) && st_ok) begin
        flags_q[st_idx] <= acc_q;
      end
      if ((cmd_q == CMD_SET_COUNT) && st_ok) begin
        counts_q[st_idx] <= cnt_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      acc_out_q <= acc_d;
      matched_q <= (cmd_q == CMD_SYMBOL) && any_hit;
    end
  end

  assign current_index_o = cur_q;
  assign accepting_o     = acc_out_q;
  assign matched_o       = matched_q;

  // A restart always lands in state zero.
  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && (cmd_q == CMD_RESTART)) |=> (cur_q == '0))
    else $error("dfa_datapath: restart did not return to state zero");

  // The state only moves when an item is applied.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.exec |=> $stable(cur_q))
    else $error("dfa_datapath: state changed without an item");

  // Only symbol items can report a fired transition.
  a_match_symbol_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && (cmd_q != CMD_SYMBOL)) |=> !matched_o)
    else $error("dfa_datapath: match reported for a load command");

endmodule

// ----- hw/rtl/programmable_dfa_matcher_core.sv -----
`timescale 1ns / 1ps

// Programmable table-driven automaton over 8-bit symbols. Each item is handled
// in an accept step and an apply step: when the item is accepted it is captured
// and the current state's whole row of transition slots is read from the table
// memory; in the apply step all slots are compared in parallel, the first hit
// picks the next state, load commands update the tables, and the result
// register is loaded. The apply step waits while an earlier result has not yet
// been taken, and no new item is accepted until the last one has been applied.
// A new item is accepted while a finished result still waits at the output.
// Accepting flags and slot counts reset to zero; the transition table has no
// reset and needs no clearing pass, so the block is ready right after reset.
module programmable_dfa_matcher_core #(
  parameter int unsigned NUM_STATES      = dfa_pkg::NumStatesDef,
  parameter int unsigned SLOTS_PER_STATE = dfa_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // state_index[3:0], slot_index[6:4], symbol[14:7], target_state[18:15],
  // accept_flag[19], slot_count[23:20]
  input  logic [23:0] s_axis_tdata_i,
  // command[2:0], entry_kind[3]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // current_index[3:0], accepting[4], matched[5], zero[7:6]
  output logic [7:0]  m_axis_tdata_o
);
  import dfa_pkg::*;

  dfa_cmd_t          ctl;
  logic [StateW-1:0] current_index;
  logic              accepting;
  logic              matched;

  // Sequencing of items and the output handshake.
  dfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .ctl_o      (ctl)
  );

  // Tables, transition search and the result register.
  dfa_datapath #(
    .NUM_STATES      (NUM_STATES),
    .SLOTS_PER_STATE (SLOTS_PER_STATE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .command_i       (s_axis_tuser_i[2:0]),
    .state_index_i   (s_axis_tdata_i[3:0]),
    .slot_index_i    (s_axis_tdata_i[6:4]),
    .entry_kind_i    (s_axis_tuser_i[3]),
    .symbol_i        (s_axis_tdata_i[14:7]),
    .target_state_i  (s_axis_tdata_i[18:15]),
    .accept_flag_i   (s_axis_tdata_i[19]),
    .slot_count_i    (s_axis_tdata_i[23:20]),
    .current_index_o (current_index),
    .accepting_o     (accepting),
    .matched_o       (matched)
  );

  assign m_axis_tdata_o = {2'b00, matched, accepting, current_index};

endmodule

// ----- tb/tb_programmable_dfa_matcher_core.sv -----
`timescale 1ns / 1ps

module tb_programmable_dfa_matcher_core;
  import dfa_pkg::*;

  // Transition kinds and codes that the package leaves unnamed.
  localparam logic            KIND_LIT      = 1'b0;
  localparam logic            KIND_CLASS    = 1'b1;
  localparam logic [SymW-1:0] CLASS_NONE    = 8'd3;
  localparam logic [CmdW-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CmdW-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int RAND_ITEMS = 1700;
  localparam int DRAIN_CYC  = 8;

  // One input item, fields named as the block sees them.
  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [StateW-1:0]   st;
    logic [SlotIdxW-1:0] slot;
    logic                kind;
    logic [SymW-1:0]     sym;
    logic [StateW-1:0]   trg;
    logic                acc;
    logic [CntW-1:0]     cnt;
  } dfa_item_t;

  // One result item, laid out as the low bits of the output tdata.
  typedef struct packed {
    logic              matched;
    logic              accepting;
    logic [StateW-1:0] cur;
  } dfa_result_t;

  // A directed row: the item, and a hand-written result where one is given.
  typedef struct {
    dfa_item_t   item;
    bit          typed;
    dfa_result_t want;
  } dfa_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic [3:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  programmable_dfa_matcher_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the automaton.
  logic [StateW-1:0] dfa_state;
  logic              acc_flag [NumStatesDef];
  logic [CntW-1:0]   row_len  [NumStatesDef];
  slot_entry_t       slot_tab [NumStatesDef][SlotsDef];
  bit                slot_set [NumStatesDef][SlotsDef];

  dfa_result_t state_results [$];
  dfa_row_t    dir_rows [$];

  int src_gap_pct  = 0;
  int sink_gap_pct = 0;
  int fail_count   = 0;
  int n_checked    = 0;
  int n_symbols    = 0;
  int n_fired      = 0;

  // True when a slot of the given entry accepts the symbol.
  function automatic logic slot_fires(slot_entry_t e, logic [SymW-1:0] sym);
    if (e.kind == KIND_LIT) begin
      return sym == e.code;
    end
    case (e.code)
      CLASS_ANY:   return 1'b1;
      CLASS_SPACE: return sym == CHAR_SPACE || sym == CHAR_TAB ||
                          sym == CHAR_LF || sym == CHAR_CR;
      CLASS_DIGIT: return sym >= CHAR_ZERO && sym <= CHAR_NINE;
      default:     return 1'b0;
    endcase
  endfunction

  // Apply one item to the shadow automaton and return the result it yields.
  function automatic dfa_result_t advance_automaton(dfa_item_t it);
    dfa_result_t res;
    logic [StateW-1:0] here;
    logic hit;
    int k;
    here = dfa_state;
    hit  = 1'b0;
    case (it.cmd)
      CMD_SET_ACCEPT: acc_flag[it.st] = it.acc;
      CMD_WRITE_SLOT: begin
        slot_tab[it.st][it.slot].kind   = it.kind;
        slot_tab[it.st][it.slot].code   = it.sym;
        slot_tab[it.st][it.slot].target = it.trg;
        slot_set[it.st][it.slot] = 1'b1;
      end
      CMD_SET_COUNT: row_len[it.st] = (it.cnt > SlotsDef) ? CntW'(SlotsDef) : it.cnt;
      CMD_RESTART:   dfa_state = '0;
      CMD_SYMBOL: begin
        for (k = 0; k < int'(row_len[here]); k++) begin
          if (!hit && slot_fires(slot_tab[here][k], it.sym)) begin
            hit       = 1'b1;
            dfa_state = slot_tab[here][k].target;
          end
        end
      end
      default: ;
    endcase
    res.cur       = dfa_state;
    res.accepting = acc_flag[dfa_state];
    res.matched   = hit;
    return res;
  endfunction

  task automatic add_row(input logic [CmdW-1:0] cmd, input logic [3:0] st,
                         input logic [2:0] slot, input logic kind,
                         input logic [7:0] sym, input logic [3:0] trg,
                         input logic acc, input logic [3:0] cnt, input int typed,
                         input logic [3:0] cur, input logic acpt, input logic hit);
    dfa_row_t r;
    r.item  = '{cmd, st, slot, kind, sym, trg, acc, cnt};
    r.typed = (typed != 0);
    r.want  = '{hit, acpt, cur};
    dir_rows.push_back(r);
  endtask

  // Random item shaped by the shadow state: mostly symbols that can fire,
  // with programming, restarts and unused commands mixed in.
  function automatic dfa_item_t draw_item();
    dfa_item_t it;
    logic [StateW-1:0] here;
    int pick;
    int k;
    here    = dfa_state;
    it.st   = 4'($urandom_range(0, 15));
    it.slot = 3'($urandom_range(0, 7));
    it.kind = 1'($urandom_range(0, 1));
    it.sym  = 8'($urandom_range(0, 255));
    it.trg  = 4'($urandom_range(0, 15));
    it.acc  = 1'($urandom_range(0, 1));
    it.cnt  = 4'($urandom_range(0, 15));
    pick    = $urandom_range(0, 99);
    if (pick < 55) begin
      it.cmd = CMD_SYMBOL;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          k = $urandom_range(0, 7);
          if (slot_set[here][k] && slot_tab[here][k].kind == KIND_LIT) begin
            it.sym = slot_tab[here][k].code;
          end
        end
        4, 5: begin
          case ($urandom_range(0, 3))
            0:       it.sym = CHAR_TAB;
            1:       it.sym = CHAR_LF;
            2:       it.sym = CHAR_CR;
            default: it.sym = CHAR_SPACE;
          endcase
        end
        6, 7: it.sym = CHAR_ZERO + 8'($urandom_range(0, 9));
        8: begin
          // Neighbors of the class boundaries.
          case ($urandom_range(0, 5))
            0:       it.sym = CHAR_TAB - 8'd1;
            1:       it.sym = CHAR_LF + 8'd1;
            2:       it.sym = CHAR_SPACE - 8'd1;
            3:       it.sym = CHAR_SPACE + 8'd1;
            4:       it.sym = CHAR_ZERO - 8'd1;
            default: it.sym = CHAR_NINE + 8'd1;
          endcase
        end
        default: ;
      endcase
    end else if (pick < 70) begin
      it.cmd = CMD_WRITE_SLOT;
      if ($urandom_range(0, 1) == 1) begin
        it.st = here;
      end
      if (it.kind == KIND_CLASS && $urandom_range(0, 7) != 0) begin
        it.sym = 8'($urandom_range(0, 3));
      end
    end else if (pick < 78) begin
      it.cmd = CMD_SET_COUNT;
      if ($urandom_range(0, 1) == 1) begin
        it.st = here;
      end
    end else if (pick < 85) begin
      it.cmd = CMD_SET_ACCEPT;
    end else if (pick < 92) begin
      it.cmd = CMD_RESTART;
    end else begin
      it.cmd = CmdW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end
    // A symbol must never scan a slot that was never written; fill the
    // lowest such slot of the current state instead.
    if (it.cmd == CMD_SYMBOL) begin
      for (k = int'(row_len[here]) - 1; k >= 0; k--) begin
        if (!slot_set[here][k]) begin
          it.cmd  = CMD_WRITE_SLOT;
          it.st   = here;
          it.slot = 3'(k);
        end
      end
    end
    return it;
  endfunction

  // Offer one item, with random gaps, and return at the edge it is taken.
  task automatic send_item(input dfa_item_t it);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {it.cnt, it.acc, it.trg, it.sym, it.slot, it.st};
    s_axis_tuser_i  <= {it.kind, it.cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input dfa_result_t want,
                                 input dfa_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected state %0d acc %0b hit %0b, got state %0d acc %0b hit %0b",
               $realtime, what, want.cur, want.accepting, want.matched,
               got.cur, got.accepting, got.matched);
    end
  endtask

  // Receiver side stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_gap_pct);
  end

  // Compare every result taken with the oldest expectation.
  dfa_result_t seen_res;
  dfa_result_t oldest_res;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_res = m_axis_tdata_o[5:0];
      if (state_results.size() == 0) begin
        report_mismatch("unexpected result", '0, seen_res);
      end else begin
        oldest_res = state_results.pop_front();
        n_checked++;
        if (seen_res.cur != oldest_res.cur || seen_res.accepting != oldest_res.accepting ||
            seen_res.matched != oldest_res.matched) begin
          report_mismatch("result mismatch", oldest_res, seen_res);
        end
      end
    end
  end

  initial begin
    dfa_item_t   it;
    dfa_result_t want;
    int idx;
    int total;
    int phase;

    dfa_state = '0;
    for (idx = 0; idx < NumStatesDef; idx++) begin
      acc_flag[idx] = 1'b0;
      row_len[idx]  = '0;
      for (phase = 0; phase < SlotsDef; phase++) begin
        slot_set[idx][phase] = 1'b0;
      end
    end

    // Directed table: reset state, unused commands, a full row of every
    // slot kind, count saturation, class order and the no-match case.
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'hFF, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b0, 1'b0);
    add_row(CMD_UNUSED_LO, 4'd15, 3'd7, KIND_CLASS, 8'hFF, 4'd15, 1'b1, 4'd15,
            1, 4'd0, 1'b0, 1'b0);
    add_row(CMD_UNUSED_HI, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b0, 1'b0);
    add_row(CMD_SET_ACCEPT, 4'd15, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b1, 4'd0,
            1, 4'd0, 1'b0, 1'b0);
    add_row(CMD_SET_ACCEPT, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b1, 4'd0, 1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd0, KIND_LIT, 8'hFF, 4'd15, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd1, KIND_CLASS, CLASS_SPACE, 4'd1, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd2, KIND_CLASS, CLASS_DIGIT, 4'd2, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd3, KIND_CLASS, 8'hFF, 4'd3, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd4, KIND_LIT, 8'h00, 4'd4, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd5, KIND_LIT, 8'h61, 4'd5, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd6, KIND_CLASS, CLASS_NONE, 4'd6, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_WRITE_SLOT, 4'd0, 3'd7, KIND_CLASS, CLASS_ANY, 4'd14, 1'b0, 4'd0,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SET_COUNT, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd15,
            1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'h35, 4'd0, 1'b0, 4'd0, 0, 4'd0, 1'b0, 1'b0);
    add_row(CMD_RESTART, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, CHAR_LF, 4'd0, 1'b0, 4'd0,
            0, 4'd0, 1'b0, 1'b0);
    add_row(CMD_RESTART, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'h03, 4'd0, 1'b0, 4'd0, 1, 4'd14, 1'b0, 1'b1);
    add_row(CMD_RESTART, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'hFF, 4'd0, 1'b0, 4'd0, 1, 4'd15, 1'b1, 1'b1);
    add_row(CMD_RESTART, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b1, 1'b0);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd4, 1'b0, 1'b1);
    add_row(CMD_SYMBOL, 4'd0, 3'd0, KIND_LIT, 8'h80, 4'd0, 1'b0, 4'd0, 1, 4'd4, 1'b0, 1'b0);
    add_row(CMD_RESTART, 4'd0, 3'd0, KIND_LIT, 8'h00, 4'd0, 1'b0, 4'd0, 1, 4'd0, 1'b1, 1'b0);

    // Reset once, then drive from the falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    total = dir_rows.size() + RAND_ITEMS;
    for (idx = 0; idx < total; idx++) begin
      // Three idle profiles: slow receiver, slow sender, then full rate.
      phase        = idx * 3 / total;
      src_gap_pct  = (phase == 0) ? 28 : (phase == 1) ? 85 : 0;
      sink_gap_pct = (phase == 0) ? 85 : (phase == 1) ? 28 : 0;
      if (idx < dir_rows.size()) begin
        it = dir_rows[idx].item;
      end else begin
        it = draw_item();
      end
      send_item(it);
      want = advance_automaton(it);
      if (it.cmd == CMD_SYMBOL) begin
        n_symbols++;
      end
      if (want.matched) begin
        n_fired++;
      end
      if (idx < dir_rows.size() && dir_rows[idx].typed) begin
        want = dir_rows[idx].want;
      end
      state_results.push_back(want);
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;

    while (state_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Ran %0d items: %0d symbols, %0d transitions fired, %0d results checked.",
             total, n_symbols, n_fired, n_checked);
    $display("Errors: %0d over three handshake pressure profiles.", fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- programmable_dfa_matcher_core.f -----
hw/rtl/dfa_pkg.sv
hw/rtl/dfa_ctrl.sv
hw/rtl/dfa_datapath.sv
hw/rtl/programmable_dfa_matcher_core.sv
tb/tb_programmable_dfa_matcher_core.sv
